[hw/rtl/pose_point_transform_top_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the pose point transform
// Clocked assertion shorthands used by the port checker.
// ----------------------------------------------------------------------------
`ifndef POSE_POINT_TRANSFORM_TOP_MACROS_SVH
`define POSE_POINT_TRANSFORM_TOP_MACROS_SVH

// Checked on every edge, muted while reset is high.
`define PPT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define PPT_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

[hw/rtl/ppt_pkg.sv]
// ----------------------------------------------------------------------------
// Pose point transform package
// Widths, quadrant codes and the quarter-wave sine table.
// ----------------------------------------------------------------------------
package ppt_pkg;

   localparam int COORD_WIDTH    = 16;
   localparam int TRIG_FRAC_BITS = 14;
   localparam int HEADING_WIDTH  = 9;

   // unsigned table entry holds 0..1.0 in Q1.F
   localparam int TABLE_W = TRIG_FRAC_BITS + 1;
   // signed trig value
   localparam int TRIG_W  = TRIG_FRAC_BITS + 2;
   localparam int PROD_W  = COORD_WIDTH + TRIG_W;
   localparam int SUM_W   = PROD_W + 1;
   localparam int WIDE_W  = SUM_W + 1;
   localparam int RND_W   = WIDE_W - TRIG_FRAC_BITS;
   localparam int OUT_W   = RND_W + 1;

   localparam int REQ_DATA_W = ((4 * COORD_WIDTH + HEADING_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((2 * COORD_WIDTH + 7) / 8) * 8;

   localparam int ANGLE_W     = 10;   // heading - 90 before wrap
   localparam int TURN_W      = 9;    // 0..359
   localparam int REM_W       = 7;    // 0..89
   localparam int HEADING_OFF = 90;
   localparam int QUARTER     = 90;
   localparam int TURN        = 360;

   localparam longint unsigned DEG_TO_RAD_Q30 = 64'd18740330;
   localparam int Q30 = 30;

   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quadrant_type;

   typedef logic [TABLE_W-1:0] sine_table_type [0:QUARTER];

   // Q30 Taylor series, truncated after each product and division,
   // rounded to TRIG_FRAC_BITS. Evaluated at elaboration only.
   function automatic logic [TABLE_W-1:0] quarter_sine(input int unsigned d);
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      x    = 64'(d) * DEG_TO_RAD_Q30;
      x2   = (x * x) >> Q30;
      term = x;
      sum  = x;
      term = ((term * x2) >> Q30) / 64'd6;   sum = sum - term;
      term = ((term * x2) >> Q30) / 64'd20;  sum = sum + term;
      term = ((term * x2) >> Q30) / 64'd42;  sum = sum - term;
      term = ((term * x2) >> Q30) / 64'd72;  sum = sum + term;
      term = ((term * x2) >> Q30) / 64'd110; sum = sum - term;
      term = ((term * x2) >> Q30) / 64'd156; sum = sum + term;
      term = ((term * x2) >> Q30) / 64'd210; sum = sum - term;
      term = ((term * x2) >> Q30) / 64'd272; sum = sum + term;
      sum  = (sum + (64'd1 << (Q30 - TRIG_FRAC_BITS - 1))) >> (Q30 - TRIG_FRAC_BITS);
      return sum[TABLE_W-1:0];
   endfunction

   function automatic sine_table_type build_sine_table();
      sine_table_type t;
      for (int unsigned d = 0; d <= QUARTER; d++) begin
         t[d] = quarter_sine(d);
      end
      return t;
   endfunction

   localparam sine_table_type SINE_TABLE = build_sine_table();

endpackage

[hw/rtl/pose_point_transform_top.sv]
// ----------------------------------------------------------------------------
// Pose point transform
// Rotates a local point by (heading - 90) degrees and offsets it by the pose.
// ----------------------------------------------------------------------------
// Usage:
//  - req_* carries one point plus its pose per transfer; rsp_* returns the
//    world point, with rsp_tuser flagging saturation of either coordinate.
//  - Four register stages: input capture, sine/cosine lookup, products,
//    then sum, round, offset and saturate into the output register.
//  - Throughput: one transfer per cycle while the output is not stalled; the
//    stages hold one item each and the product stage forms four 16 x 16
//    bit products side by side.
//  - Stall: each stage moves forward only when the next one is empty or
//    moving, so bubbles are squeezed out and new items are still taken
//    while a result waits; req_tready drops once every stage is full and
//    rsp_tready is low. Reset (synchronous, active high) empties all stages;
//    rsp_tvalid is low after reset. No configuration, no state between items.
// ----------------------------------------------------------------------------
module pose_point_transform_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // point_x [15:0], point_y [31:16], pose_x [47:32], pose_y [63:48],
   // pose_heading [72:64], zero pad above
   input  logic [ppt_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // world_x [15:0], world_y [31:16]
   output logic [ppt_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // clipped [0]
   output logic                              rsp_tuser
);

   localparam int CW = ppt_pkg::COORD_WIDTH;
   localparam int F  = ppt_pkg::TRIG_FRAC_BITS;

   // ---------------- stage enables ----------------
   logic a_vld_ff, b_vld_ff, c_vld_ff, rsp_vld_ff;
   logic a_vld_in, b_vld_in, c_vld_in, rsp_vld_in;
   logic out_en, c_en, b_en, a_en;

   assign out_en     = !rsp_vld_ff || rsp_tready;
   assign c_en       = !c_vld_ff || out_en;
   assign b_en       = !b_vld_ff || c_en;
   assign a_en       = !a_vld_ff || b_en;
   assign req_tready = a_en;

   assign a_vld_in   = a_en   ? req_tvalid : a_vld_ff;
   assign b_vld_in   = b_en   ? a_vld_ff   : b_vld_ff;
   assign c_vld_in   = c_en   ? b_vld_ff   : c_vld_ff;
   assign rsp_vld_in = out_en ? c_vld_ff   : rsp_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff   <= 1'b0;
         b_vld_ff   <= 1'b0;
         c_vld_ff   <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         a_vld_ff   <= a_vld_in;
         b_vld_ff   <= b_vld_in;
         c_vld_ff   <= c_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   // ---------------- stage A: input capture ----------------
   logic signed [CW-1:0]                       a_px_ff, a_py_ff, a_ox_ff, a_oy_ff;
   logic signed [ppt_pkg::HEADING_WIDTH-1:0]   a_hd_ff;

   always_ff @(posedge clock) begin
      if (a_en) begin
         a_px_ff <= req_tdata[CW-1:0];
         a_py_ff <= req_tdata[2*CW-1:CW];
         a_ox_ff <= req_tdata[3*CW-1:2*CW];
         a_oy_ff <= req_tdata[4*CW-1:3*CW];
         a_hd_ff <= req_tdata[4*CW+ppt_pkg::HEADING_WIDTH-1:4*CW];
      end
   end

   // ---------------- angle wrap and table lookup ----------------
   logic signed [ppt_pkg::ANGLE_W-1:0] angle;
   logic        [ppt_pkg::TURN_W-1:0]  turn;
   logic        [ppt_pkg::REM_W-1:0]   rem;
   logic        [ppt_pkg::REM_W-1:0]   rem_co;
   ppt_pkg::quadrant_type              quad;
   logic        [ppt_pkg::TABLE_W-1:0] sin_r, cos_r;
   logic signed [ppt_pkg::TRIG_W-1:0]  sin_p, cos_p;
   logic signed [ppt_pkg::TRIG_W-1:0]  b_s_in, b_c_in;

   always_comb begin
      // heading - 90, always above -360, so one wrap suffices
      angle = ppt_pkg::ANGLE_W'(signed'(a_hd_ff)) - ppt_pkg::ANGLE_W'(ppt_pkg::HEADING_OFF);
      if (angle < 0) begin
         turn = ppt_pkg::TURN_W'(angle + ppt_pkg::ANGLE_W'(ppt_pkg::TURN));
      end else begin
         turn = ppt_pkg::TURN_W'(angle);
      end

      priority if (turn >= ppt_pkg::TURN_W'(3 * ppt_pkg::QUARTER)) begin
         quad = ppt_pkg::QUAD_3;
         rem  = ppt_pkg::REM_W'(turn - ppt_pkg::TURN_W'(3 * ppt_pkg::QUARTER));
      end else if (turn >= ppt_pkg::TURN_W'(2 * ppt_pkg::QUARTER)) begin
         quad = ppt_pkg::QUAD_2;
         rem  = ppt_pkg::REM_W'(turn - ppt_pkg::TURN_W'(2 * ppt_pkg::QUARTER));
      end else if (turn >= ppt_pkg::TURN_W'(ppt_pkg::QUARTER)) begin
         quad = ppt_pkg::QUAD_1;
         rem  = ppt_pkg::REM_W'(turn - ppt_pkg::TURN_W'(ppt_pkg::QUARTER));
      end else begin
         quad = ppt_pkg::QUAD_0;
         rem  = ppt_pkg::REM_W'(turn);
      end

      rem_co = ppt_pkg::REM_W'(ppt_pkg::QUARTER) - rem;
      sin_r  = ppt_pkg::SINE_TABLE[rem];
      cos_r  = ppt_pkg::SINE_TABLE[rem_co];
      sin_p  = signed'({1'b0, sin_r});
      cos_p  = signed'({1'b0, cos_r});

      unique case (quad)
         ppt_pkg::QUAD_0: begin b_s_in = sin_p;  b_c_in = cos_p;  end
         ppt_pkg::QUAD_1: begin b_s_in = cos_p;  b_c_in = -sin_p; end
         ppt_pkg::QUAD_2: begin b_s_in = -sin_p; b_c_in = -cos_p; end
         ppt_pkg::QUAD_3: begin b_s_in = -cos_p; b_c_in = sin_p;  end
         default:         begin b_s_in = sin_p;  b_c_in = cos_p;  end
      endcase
   end

   // ---------------- stage B: trig values ----------------
   logic signed [CW-1:0]               b_px_ff, b_py_ff, b_ox_ff, b_oy_ff;
   logic signed [ppt_pkg::TRIG_W-1:0]  b_s_ff, b_c_ff;

   always_ff @(posedge clock) begin
      if (b_en) begin
         b_px_ff <= a_px_ff;
         b_py_ff <= a_py_ff;
         b_ox_ff <= a_ox_ff;
         b_oy_ff <= a_oy_ff;
         b_s_ff  <= b_s_in;
         b_c_ff  <= b_c_in;
      end
   end

   // ---------------- stage C: products ----------------
   logic signed [ppt_pkg::PROD_W-1:0] c_xc_ff, c_ys_ff, c_yc_ff, c_xs_ff;
   logic signed [CW-1:0]              c_ox_ff, c_oy_ff;

   always_ff @(posedge clock) begin
      if (c_en) begin
         c_xc_ff <= ppt_pkg::PROD_W'(b_px_ff) * ppt_pkg::PROD_W'(b_c_ff);
         c_ys_ff <= ppt_pkg::PROD_W'(b_py_ff) * ppt_pkg::PROD_W'(b_s_ff);
         c_yc_ff <= ppt_pkg::PROD_W'(b_py_ff) * ppt_pkg::PROD_W'(b_c_ff);
         c_xs_ff <= ppt_pkg::PROD_W'(b_px_ff) * ppt_pkg::PROD_W'(b_s_ff);
         c_ox_ff <= b_ox_ff;
         c_oy_ff <= b_oy_ff;
      end
   end

   // ---------------- sum, round, offset, saturate ----------------
   logic signed [ppt_pkg::WIDE_W-1:0] wide_x, wide_y;
   logic signed [ppt_pkg::RND_W-1:0]  rnd_x, rnd_y;
   logic signed [ppt_pkg::OUT_W-1:0]  full_x, full_y;
   logic                              fit_x, fit_y;
   logic        [CW-1:0]              rsp_x_in, rsp_y_in;
   logic                              rsp_clip_in;

   always_comb begin
      // round half toward +inf: add half an LSB, floor by dropping bits
      wide_x = ppt_pkg::WIDE_W'(c_xc_ff) - ppt_pkg::WIDE_W'(c_ys_ff)
             + (ppt_pkg::WIDE_W'(1) << (F - 1));
      wide_y = ppt_pkg::WIDE_W'(c_yc_ff) + ppt_pkg::WIDE_W'(c_xs_ff)
             + (ppt_pkg::WIDE_W'(1) << (F - 1));
      rnd_x  = wide_x[ppt_pkg::WIDE_W-1:F];
      rnd_y  = wide_y[ppt_pkg::WIDE_W-1:F];
      full_x = ppt_pkg::OUT_W'(rnd_x) + ppt_pkg::OUT_W'(c_ox_ff);
      full_y = ppt_pkg::OUT_W'(rnd_y) + ppt_pkg::OUT_W'(c_oy_ff);

      // in range when every bit above the coordinate sign matches it
      fit_x = (full_x[ppt_pkg::OUT_W-1:CW-1] == '0) || (full_x[ppt_pkg::OUT_W-1:CW-1] == '1);
      fit_y = (full_y[ppt_pkg::OUT_W-1:CW-1] == '0) || (full_y[ppt_pkg::OUT_W-1:CW-1] == '1);

      if (fit_x) begin
         rsp_x_in = full_x[CW-1:0];
      end else begin
         rsp_x_in = {full_x[ppt_pkg::OUT_W-1], {(CW-1){~full_x[ppt_pkg::OUT_W-1]}}};
      end
      if (fit_y) begin
         rsp_y_in = full_y[CW-1:0];
      end else begin
         rsp_y_in = {full_y[ppt_pkg::OUT_W-1], {(CW-1){~full_y[ppt_pkg::OUT_W-1]}}};
      end
      rsp_clip_in = !fit_x || !fit_y;
   end

   // ---------------- output register ----------------
   logic [CW-1:0] rsp_x_ff, rsp_y_ff;
   logic          rsp_clip_ff;

   always_ff @(posedge clock) begin
      if (out_en) begin
         rsp_x_ff    <= rsp_x_in;
         rsp_y_ff    <= rsp_y_in;
         rsp_clip_ff <= rsp_clip_in;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = ppt_pkg::RSP_DATA_W'({rsp_y_ff, rsp_x_ff});
   assign rsp_tuser  = rsp_clip_ff;

endmodule

[hw/rtl/ppt_checker.sv]
// ----------------------------------------------------------------------------
// Pose point transform port checker
// Watches the top-level ports for reset, stall and saturation behavior.
// ----------------------------------------------------------------------------
`include "pose_point_transform_top_macros.svh"

module ppt_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic [ppt_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [ppt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tuser
);

   localparam int CW = ppt_pkg::COORD_WIDTH;

   logic          req_xfer;
   logic [CW-1:0] wx, wy;
   logic          x_at_limit, y_at_limit;

   assign req_xfer   = req_tvalid && req_tready && (req_tdata == req_tdata);
   assign wx         = rsp_tdata[CW-1:0];
   assign wy         = rsp_tdata[2*CW-1:CW];
   assign x_at_limit = (wx == {1'b0, {(CW-1){1'b1}}}) || (wx == {1'b1, {(CW-1){1'b0}}});
   assign y_at_limit = (wy == {1'b0, {(CW-1){1'b1}}}) || (wy == {1'b1, {(CW-1){1'b0}}});

   // output side empties on reset
   `PPT_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "rsp_tvalid high after reset")

   // a fresh result always comes from a transfer that ran unstalled through stages A, B and C
   `PPT_ASSERT(a_min_latency, $rose(rsp_tvalid) |-> $past(req_xfer, 4), "no prior transfer")

   // a saturated result sits on a coordinate limit
   `PPT_ASSERT(a_clip_limit,
               rsp_tvalid && rsp_tuser |-> x_at_limit || y_at_limit,
               "clipped without limit value")

   // stalled result holds
   `PPT_ASSERT(a_stall_hold,
               rsp_tvalid && !rsp_tready |=>
                  rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser),
               "stalled result changed")

endmodule

bind pose_point_transform_top ppt_checker u_ppt_checker (.*);

[verif/pose_point_checker.sv]
// ----------------------------------------------------------------------------
// Pose point transform checker
// Watches both streams. For each accepted request it predicts the world
// point, then compares every response, field by field, with the oldest one.
// ----------------------------------------------------------------------------
module pose_point_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [ppt_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [ppt_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           rsp_tuser,
   output int                             fault_count,
   output int                             pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW   = ppt_pkg::COORD_WIDTH;
   localparam int FRAC = ppt_pkg::TRIG_FRAC_BITS;

   typedef struct {
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic                 clip;
   } world_point_type;

   world_point_type expected_world [$];
   int              sine_q14 [0:ppt_pkg::QUARTER];
   int              faults = 0;

   // sin(deg) for deg 0..90 as a Q30 Taylor series to x^17, rounded to FRAC bits
   function automatic int quarter_wave_sine(input int unsigned deg);
      longint unsigned ang;
      longint unsigned ang_sq;
      longint unsigned term;
      longint unsigned acc;
      ang    = 64'(deg) * ppt_pkg::DEG_TO_RAD_Q30;
      ang_sq = (ang * ang) >> ppt_pkg::Q30;
      term   = ang;
      acc    = ang;
      for (int k = 1; k <= 8; k++) begin
         term = ((term * ang_sq) >> ppt_pkg::Q30) / 64'((2 * k) * (2 * k + 1));
         if (k % 2 == 1) acc = acc - term;
         else            acc = acc + term;
      end
      acc = (acc + (64'd1 << (ppt_pkg::Q30 - FRAC - 1))) >> (ppt_pkg::Q30 - FRAC);
      return int'(acc);
   endfunction

   initial begin
      for (int d = 0; d <= ppt_pkg::QUARTER; d++) sine_q14[d] = quarter_wave_sine(d);
   end

   // round to whole mm, halves toward +inf
   function automatic longint round_mm(input longint v);
      return (v + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
   endfunction

   function automatic longint clamp_coord(input longint v, inout logic clip);
      longint hi;
      longint lo;
      hi = (64'sd1 <<< (CW - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin
         clip = 1'b1;
         return hi;
      end
      if (v < lo) begin
         clip = 1'b1;
         return lo;
      end
      return v;
   endfunction

   function automatic world_point_type predict_world(input logic [ppt_pkg::REQ_DATA_W-1:0] d);
      logic signed [CW-1:0]                    px, py, ox, oy;
      logic signed [ppt_pkg::HEADING_WIDTH-1:0] hd;
      int                                      turn;
      int                                      rem;
      longint                                  s, c, sr, cr, wx, wy;
      ppt_pkg::quadrant_type                   quad;
      world_point_type                         w;
      px = d[CW-1:0];
      py = d[2*CW-1:CW];
      ox = d[3*CW-1:2*CW];
      oy = d[4*CW-1:3*CW];
      hd = d[4*CW+ppt_pkg::HEADING_WIDTH-1:4*CW];
      // remainder, plus 360 when negative, gives (heading - 90) mod 360 in 0..359
      turn = (int'(hd) - ppt_pkg::HEADING_OFF) % ppt_pkg::TURN;
      if (turn < 0) turn += ppt_pkg::TURN;
      quad = ppt_pkg::quadrant_type'(turn / ppt_pkg::QUARTER);
      rem  = turn % ppt_pkg::QUARTER;
      sr   = sine_q14[rem];
      cr   = sine_q14[ppt_pkg::QUARTER - rem];
      case (quad)
         ppt_pkg::QUAD_0: begin s = sr;  c = cr;  end
         ppt_pkg::QUAD_1: begin s = cr;  c = -sr; end
         ppt_pkg::QUAD_2: begin s = -sr; c = -cr; end
         default:         begin s = -cr; c = sr;  end
      endcase
      wx = round_mm(longint'(px) * c - longint'(py) * s) + longint'(ox);
      wy = round_mm(longint'(py) * c + longint'(px) * s) + longint'(oy);
      w.clip = 1'b0;
      w.x    = CW'(clamp_coord(wx, w.clip));
      w.y    = CW'(clamp_coord(wy, w.clip));
      return w;
   endfunction

   always @(posedge clock) begin : watch
      world_point_type got;
      world_point_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) expected_world.push_back(predict_world(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            got.x    = rsp_tdata[CW-1:0];
            got.y    = rsp_tdata[2*CW-1:CW];
            got.clip = rsp_tuser;
            if (expected_world.size() == 0) begin
               $display("%0t: unexpected response x=%0d y=%0d clipped=%0b",
                        $time, got.x, got.y, got.clip);
               faults++;
            end else begin
               want = expected_world.pop_front();
               if (got.x !== want.x) begin
                  $display("%0t: world_x expected %0d actual %0d", $time, want.x, got.x);
                  faults++;
               end
               if (got.y !== want.y) begin
                  $display("%0t: world_y expected %0d actual %0d", $time, want.y, got.y);
                  faults++;
               end
               if (got.clip !== want.clip) begin
                  $display("%0t: clipped expected %0b actual %0b", $time, want.clip, got.clip);
                  faults++;
               end
            end
         end
      end
      fault_count   <= faults;
      pending_count <= expected_world.size();
   end

endmodule

[verif/tb_top.sv]
// ----------------------------------------------------------------------------
// Pose point transform testbench
// Drives points and poses into the transform, with directed corner cases
// followed by random traffic under four idle/stall profiles. A checker
// beside the block predicts every world point and counts mismatches.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW         = ppt_pkg::COORD_WIDTH;
   localparam int HW         = ppt_pkg::HEADING_WIDTH;
   localparam int RAND_ITEMS = 900;
   localparam int HOLD_OFF   = 50;     // initial receiver hold-off, cycles
   localparam int DRAIN      = 20;     // cycles after the last response

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [ppt_pkg::REQ_DATA_W-1:0] req_tdata;    // point_x, point_y, pose_x, pose_y, heading
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [ppt_pkg::RSP_DATA_W-1:0] rsp_tdata;    // world_x, world_y
   logic                           rsp_tuser;    // clipped
   int                             fault_count;
   int                             pending_count;

   // idle and stall odds in percent, set per phase by the stimulus
   int idle_pct  = 0;
   int stall_pct = 0;

   pose_point_transform_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   pose_point_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser),
      .fault_count   (fault_count),
      .pending_count (pending_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Safety net: ends a hung run with a failure, long after the slowest
   // legal run would have finished.
   initial begin
      #2ms;
      $display("tb: failure");
      $finish;
   end

   // Receiver side. Holds off right after reset while the directed points
   // stream in, so the pipe fills and req_tready has to drop; after that it
   // stalls at the odds of the current phase.
   initial begin : rsp_side
      int held;
      rsp_tready = 1'b0;
      while (reset !== 1'b0) @(negedge clock);
      for (held = 0; held < HOLD_OFF; held++) @(negedge clock);
      forever begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
         @(negedge clock);
      end
   end

   // One transfer. Called at a falling edge, returns at the falling edge
   // after the accepting rising edge; every edge gets one assignment only.
   task automatic send_point(input logic [CW-1:0] px, input logic [CW-1:0] py,
                             input logic [CW-1:0] ox, input logic [CW-1:0] oy,
                             input logic [HW-1:0] hd);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= ppt_pkg::REQ_DATA_W'({hd, oy, ox, py, px});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   // Random coordinate: half full range, half near the origin.
   function automatic logic [CW-1:0] rand_coord();
      if ($urandom_range(1) == 0) return CW'($urandom);
      return CW'(int'($urandom_range(4000)) - 2000);
   endfunction

   // Random heading: mostly the nominal -179..180, sometimes any 9-bit value.
   function automatic logic [HW-1:0] rand_heading();
      if ($urandom_range(3) == 0) return HW'($urandom);
      return HW'(int'($urandom_range(359)) - 179);
   endfunction

   initial begin : stimulus
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: heading 90 is a pure offset; the rest walk every quadrant
      // and the out-of-range 9-bit headings.
      send_point(16'sd0,      16'sd0,      16'sd0,      16'sd0,      9'sd90);
      send_point(16'sd100,    -16'sd250,   16'sd1000,   -16'sd2000,  9'sd90);
      send_point(16'sd1000,   16'sd0,      16'sd0,      16'sd0,      9'sd180);
      send_point(16'sd1000,   16'sd0,      16'sd0,      16'sd0,      -9'sd90);
      send_point(16'sd1000,   16'sd0,      16'sd0,      16'sd0,      9'sd0);
      send_point(16'sd1000,   16'sd500,    16'sd7,      -16'sd7,     -9'sd179);
      send_point(16'sd1234,   -16'sd4321,  16'sd0,      16'sd0,      9'sd45);
      send_point(-16'sd1234,  16'sd4321,   16'sd0,      16'sd0,      9'sd135);
      send_point(16'sd3000,   16'sd3000,   16'sd0,      16'sd0,      -9'sd135);
      send_point(16'sd2000,   -16'sd1500,  16'sd10,     16'sd20,     -9'sd256);
      send_point(16'sd2000,   -16'sd1500,  16'sd10,     16'sd20,     9'sd255);
      send_point(16'sd999,    16'sd111,    16'sd0,      16'sd0,      -9'sd180);
      send_point(16'sd999,    16'sd111,    16'sd0,      16'sd0,      9'sd181);
      send_point(16'sd999,    16'sd111,    16'sd0,      16'sd0,      -9'sd1);
      // exact halves at 30 degrees: +0.5 rounds up, -0.5 rounds to zero
      send_point(16'sd1,      16'sd0,      16'sd0,      16'sd0,      9'sd120);
      send_point(-16'sd1,     16'sd0,      16'sd0,      16'sd0,      9'sd120);
      // field extremes, with saturation both ways
      send_point(16'sh7fff,   16'sh8000,   16'sh7fff,   16'sh8000,   9'sd90);
      send_point(16'sh8000,   16'sh7fff,   16'sh8000,   16'sh7fff,   9'sd90);
      send_point(16'sh7fff,   16'sh7fff,   16'sd0,      16'sd0,      9'sd135);
      send_point(16'sh8000,   16'sh8000,   16'sh8000,   16'sh8000,   9'sd135);
      send_point(16'sh8000,   16'sh8000,   16'sh7fff,   16'sh7fff,   9'sd270);
      send_point(16'shffff,   16'shffff,   16'shffff,   16'shffff,   9'h1ff);
      send_point(16'sh7fff,   16'sh7fff,   16'sh7fff,   16'sh7fff,   9'h0ff);

      // Random part in four profiles: none, sender idle, receiver stall, both.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 81; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 81; end
            default: begin idle_pct = 16; stall_pct = 16; end
         endcase
         for (int n = 0; n < RAND_ITEMS / 4; n++)
            send_point(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                       rand_heading());
      end
      req_tvalid <= 1'b0;

      // drain: everything predicted must come back, then a few quiet cycles
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (fault_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/ppt_pkg.sv
hw/rtl/pose_point_transform_top.sv
hw/rtl/ppt_checker.sv
verif/pose_point_checker.sv
verif/tb_top.sv
